// File: hw/rtl/qrci_pkg.sv
// Shared types, constants and helper functions of the quarter ring cluster integrator.
package qrci_pkg;

    // Store geometry
    localparam int DISK_SLOTS = 8;
    localparam int RINGS      = 5;
    localparam int QUARTERS   = 4;
    localparam int COUNT_BITS = 32;
    localparam int SIDES      = 2;

    // Detector numbering
    localparam logic [3:0] FIRST_DISK = 4'd9;
    localparam logic [3:0] LAST_DISK  = 4'd12;
    localparam logic [3:0] INNER_DISK = 4'd12;
    localparam logic [2:0] MAX_RING   = 3'd5;
    localparam logic [1:0] SIDE_MINUS = 2'd1;
    localparam logic [1:0] SIDE_PLUS  = 2'd2;

    // Input and output field widths
    localparam int CNT_IN_W = 16;
    localparam int OUT_W    = 32;
    localparam int SLOT_W   = 3;
    localparam int EV_W     = 14;
    localparam int WIN_W    = 15;
    localparam logic [WIN_W-1:0] MAX_WINDOW = 15'd16384;

    // Row stores
    localparam int WROWS   = DISK_SLOTS * RINGS;
    localparam int WADDR_W = (WROWS > 1) ? $clog2(WROWS) : 1;
    localparam int IROWS   = SIDES;
    localparam int IADDR_W = (IROWS > 1) ? $clog2(IROWS) : 1;
    localparam int DCNT_W  = (DISK_SLOTS > 1) ? $clog2(DISK_SLOTS) : 1;
    localparam int RCNT_W  = (RINGS > 1) ? $clog2(RINGS) : 1;

    // Operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_EVENT  = 1'b1;

    // Row kinds
    localparam logic KIND_WIDE  = 1'b0;
    localparam logic KIND_INNER = 1'b1;

    // Configuration register indexes
    localparam logic REG_WIDE_WIN  = 1'b0;
    localparam logic REG_INNER_WIN = 1'b1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [QUARTERS-1:0][COUNT_BITS-1:0] row_t;

    typedef struct packed {
        logic [WIN_W-1:0] wide_win;
        logic [WIN_W-1:0] inner_win;
    } win_cfg_t;

    typedef struct packed {
        logic               wide_rd;
        logic               inner_rd;
        logic [WADDR_W-1:0] wide_addr;
        logic [IADDR_W-1:0] inner_addr;
        logic [SLOT_W-1:0]  disk_slot;
        logic [SLOT_W-1:0]  ring_slot;
        logic               last;
    } flush_cmd_t;

    // Modules per quarter of each ring
    function automatic logic [3:0] quarter_span(input logic [2:0] ring_idx);
        logic [3:0] span;
        case (ring_idx)
            3'd0:    span = 4'd5;
            3'd1:    span = 4'd7;
            3'd2:    span = 4'd9;
            3'd3:    span = 4'd11;
            3'd4:    span = 4'd12;
            default: span = 4'd5;
        endcase
        return span;
    endfunction

    // Map a module position to its quarter of the ring
    function automatic logic [1:0] quarter_of(input logic [2:0] ring_idx,
                                              input logic [5:0] module_pos);
        logic [6:0] q1;
        logic [6:0] q2;
        logic [6:0] q3;
        logic [6:0] m;
        logic [1:0] q;
        q1 = {3'b000, quarter_span(ring_idx)};
        q2 = q1 << 1;
        q3 = q1 + q2;
        m  = {1'b0, module_pos};
        if (m <= q1)
            q = 2'd0;
        else if (m <= q2)
            q = 2'd1;
        else if (m <= q3)
            q = 2'd2;
        else
            q = 2'd3;
        return q;
    endfunction

    // Saturating counter add
    function automatic count_t sat_add(input count_t a, input logic [CNT_IN_W-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + (COUNT_BITS + 1)'(b);
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    // Clamp a window setting to 1..MAX_WINDOW
    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] e;
        if (w == '0)
            e = WIN_W'(1);
        else if (w > MAX_WINDOW)
            e = MAX_WINDOW;
        else
            e = w;
        return e;
    endfunction

endpackage

// File: hw/rtl/qrci_store.sv
// Row store: synchronous RAM with per-row valid bits and clear on read.
module qrci_store
    import qrci_pkg::*;
#(
    parameter int DEPTH  = 40,
    parameter int WIDTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic              rd_clr,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] data_reg;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             rd_vld_reg;

    // Read and write the array
    always_ff @(posedge clk)
    begin
        if (rd_en)
            data_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Drop a row's valid bit on a clearing read, raise it on a write
    always_comb
    begin
        vld_next = vld_reg;
        if (rd_en && rd_clr)
            vld_next[rd_addr] = 1'b0;
        if (wr_en)
            vld_next[wr_addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
                rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // A row never written since reset or last clear reads as zero
    assign rd_data = rd_vld_reg ? data_reg : '0;

endmodule

// File: hw/rtl/qrci_apb.sv
// APB configuration registers holding the two event windows.
module qrci_apb
    import qrci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output win_cfg_t    cfg
);

    logic [WIN_W-1:0] wide_win_reg;
    logic [WIN_W-1:0] inner_win_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write the addressed window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_win_reg  <= WIN_W'(1);
            inner_win_reg <= WIN_W'(1);
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_WIDE_WIN:  wide_win_reg  <= pwdata[WIN_W-1:0];
                REG_INNER_WIN: inner_win_reg <= pwdata[WIN_W-1:0];
                default:       wide_win_reg  <= wide_win_reg;
            endcase
        end
    end

    // Return the addressed window
    always_comb
    begin
        case (paddr[2])
            REG_WIDE_WIN:  prdata = {{(32 - WIN_W){1'b0}}, wide_win_reg};
            REG_INNER_WIN: prdata = {{(32 - WIN_W){1'b0}}, inner_win_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.wide_win  = wide_win_reg;
    assign cfg.inner_win = inner_win_reg;

endmodule

// File: hw/rtl/qrci_flush.sv
// Flush sequencer: walks the wide rows, the inner rows or both (wide first), one read a cycle.
module qrci_flush
    import qrci_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start_wide,
    input  logic       start_inner,
    output logic       busy,
    output flush_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WIDE  = 2'd1;
    localparam logic [1:0] S_INNER = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic               inner_pend_reg;
    logic               inner_pend_next;
    logic [WADDR_W-1:0] row_reg;
    logic [WADDR_W-1:0] row_next;
    logic [DCNT_W-1:0]  d_reg;
    logic [DCNT_W-1:0]  d_next;
    logic [RCNT_W-1:0]  r_reg;
    logic [RCNT_W-1:0]  r_next;
    logic [IADDR_W-1:0] s_reg;
    logic [IADDR_W-1:0] s_next;
    logic               wide_end;
    logic               inner_end;

    assign wide_end  = (row_reg == WADDR_W'(WROWS - 1));
    assign inner_end = (s_reg == IADDR_W'(IROWS - 1));
    assign busy      = (state_reg != S_IDLE);

    // Advance through the rows
    always_comb
    begin
        state_next      = state_reg;
        inner_pend_next = inner_pend_reg;
        row_next        = row_reg;
        d_next          = d_reg;
        r_next          = r_reg;
        s_next          = s_reg;
        case (state_reg)
            S_IDLE:
            begin
                row_next        = '0;
                d_next          = '0;
                r_next          = '0;
                s_next          = '0;
                inner_pend_next = start_inner;
                if (start_wide)
                    state_next = S_WIDE;
                else if (start_inner)
                    state_next = S_INNER;
            end
            S_WIDE:
            begin
                row_next = row_reg + WADDR_W'(1);
                if (r_reg == RCNT_W'(RINGS - 1))
                begin
                    r_next = '0;
                    d_next = d_reg + DCNT_W'(1);
                end
                else
                begin
                    r_next = r_reg + RCNT_W'(1);
                end
                if (wide_end)
                    state_next = inner_pend_reg ? S_INNER : S_IDLE;
            end
            S_INNER:
            begin
                s_next = s_reg + IADDR_W'(1);
                if (inner_end)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            inner_pend_reg <= 1'b0;
            row_reg        <= '0;
            d_reg          <= '0;
            r_reg          <= '0;
            s_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            inner_pend_reg <= inner_pend_next;
            row_reg        <= row_next;
            d_reg          <= d_next;
            r_reg          <= r_next;
            s_reg          <= s_next;
        end
    end

    // Drive the read command for the current row
    always_comb
    begin
        cmd.wide_rd    = (state_reg == S_WIDE);
        cmd.inner_rd   = (state_reg == S_INNER);
        cmd.wide_addr  = row_reg;
        cmd.inner_addr = s_reg;
        if (state_reg == S_INNER)
        begin
            cmd.disk_slot = SLOT_W'(s_reg);
            cmd.ring_slot = '0;
            cmd.last      = inner_end;
        end
        else
        begin
            cmd.disk_slot = SLOT_W'(d_reg);
            cmd.ring_slot = SLOT_W'(r_reg);
            cmd.last      = wide_end && !inner_pend_reg;
        end
    end

endmodule

// File: hw/rtl/quarter_ring_cluster_integrator.sv
// Top level: record update pipeline, event windows and row output of the integrator.
//
// Usage
//   Input: present op and the record fields with start high; the word is taken
//   at the rising edge where start is high and busy is low. op 0 adds a module's
//   cluster count to its quarter ring counter, op 1 marks the end of an event.
//   Output: each row is shown for one cycle with strobe high; the receiver must
//   take it then. An end of event that reaches the wide window emits all 40 wide
//   rows (disk slot major, ring minor), one that reaches the inner window the two
//   inner rows, after the wide rows if both; last_row marks the final one.
//   Throughput: one record per cycle while busy is low. Each record does a
//   read-modify-write of one row in the 40x128 wide RAM (and the 2x128 inner RAM);
//   a write-back register forwards the row to a record that follows on the same row.
//   Flush: busy stays high while the rows are read, one RAM read per emitted row,
//   as each RAM has a single read port; each row passes the sequencer state, the
//   flush read stage and the output stage, and rows follow one per cycle.
//   Reset: clears the row valid bits so both stores read as zero, zeroes the
//   event counters and sets both windows to 1. No clearing pass is needed.
//   Configuration: APB, window registers at byte addresses 0 and 4.
module quarter_ring_cluster_integrator
    import qrci_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input words
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic                forward_pixel,
    input  logic [1:0]          side_number,
    input  logic [3:0]          disk_number,
    input  logic [2:0]          ring_number,
    input  logic [5:0]          module_number,
    input  logic [CNT_IN_W-1:0] cluster_count,
    // result words
    output logic                strobe,
    output logic                record_kind,
    output logic [SLOT_W-1:0]   disk_slot,
    output logic [SLOT_W-1:0]   ring_slot,
    output logic [OUT_W-1:0]    count_quarter0,
    output logic [OUT_W-1:0]    count_quarter1,
    output logic [OUT_W-1:0]    count_quarter2,
    output logic [OUT_W-1:0]    count_quarter3,
    output logic                last_row
);

    win_cfg_t   cfg;
    flush_cmd_t cmd;
    logic       flush_busy;

    logic       accept;
    logic       rec_acc;
    logic       ev_acc;

    // record decode
    logic [3:0]         disk_off;
    logic [3:0]         dslot_full;
    logic [2:0]         ring_idx;
    logic [7:0]         row_full;
    logic               rec_ok;
    logic               wide_hit;
    logic               inner_hit;
    logic [1:0]         quarter;
    logic [IADDR_W-1:0] side_idx;

    // update stage
    logic                upd_w_vld_reg;
    logic                upd_i_vld_reg;
    logic [WADDR_W-1:0]  upd_row_reg;
    logic [IADDR_W-1:0]  upd_side_reg;
    logic [1:0]          upd_q_reg;
    logic [CNT_IN_W-1:0] upd_cnt_reg;

    // write-back forwarding
    logic               fw_w_vld_reg;
    logic [WADDR_W-1:0] fw_w_row_reg;
    row_t               fw_w_data_reg;
    logic               fw_i_vld_reg;
    logic [IADDR_W-1:0] fw_i_addr_reg;
    row_t               fw_i_data_reg;

    row_t w_rd_data;
    row_t i_rd_data;
    row_t w_base;
    row_t i_base;
    row_t w_new;
    row_t i_new;

    logic               w_rd_en;
    logic [WADDR_W-1:0] w_rd_addr;
    logic               i_rd_en;
    logic [IADDR_W-1:0] i_rd_addr;

    // event windows
    logic [EV_W-1:0]  wide_ev_reg;
    logic [EV_W-1:0]  wide_ev_next;
    logic [EV_W-1:0]  inner_ev_reg;
    logic [EV_W-1:0]  inner_ev_next;
    logic [WIN_W-1:0] wide_inc;
    logic [WIN_W-1:0] inner_inc;
    logic             fire_w;
    logic             fire_i;

    // flush read stage
    logic              fl_vld_reg;
    logic              fl_kind_reg;
    logic [SLOT_W-1:0] fl_dslot_reg;
    logic [SLOT_W-1:0] fl_rslot_reg;
    logic              fl_last_reg;
    row_t              fl_data;

    // output stage
    logic              out_vld_reg;
    logic              out_kind_reg;
    logic [SLOT_W-1:0] out_dslot_reg;
    logic [SLOT_W-1:0] out_rslot_reg;
    row_t              out_data_reg;
    logic              out_last_reg;

    qrci_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy    = flush_busy;
    assign accept  = start && !flush_busy;
    assign rec_acc = accept && (op == OP_RECORD);
    assign ev_acc  = accept && (op == OP_EVENT);

    // Decode the record into row address and quarter
    always_comb
    begin
        disk_off   = disk_number - FIRST_DISK;
        dslot_full = 4'(({2'b00, side_number} - 4'd1) * 4'd4 + disk_off);
        ring_idx   = ring_number - 3'd1;
        row_full   = 8'(dslot_full) * 8'(RINGS) + 8'(ring_idx);
        side_idx   = IADDR_W'(side_number - SIDE_MINUS);
        quarter    = quarter_of(ring_idx, module_number);
        rec_ok     = forward_pixel
                     && (side_number == SIDE_MINUS || side_number == SIDE_PLUS)
                     && (disk_number >= FIRST_DISK) && (disk_number <= LAST_DISK)
                     && (ring_number >= 3'd1) && (ring_number <= MAX_RING);
        wide_hit   = rec_ok && (dslot_full < 4'(DISK_SLOTS)) && (ring_idx < 3'(RINGS));
        inner_hit  = rec_ok && (disk_number == INNER_DISK) && (ring_number == 3'd1);
    end

    // Share the read ports between records and the flush sequencer
    assign w_rd_en   = (rec_acc && wide_hit) || cmd.wide_rd;
    assign w_rd_addr = cmd.wide_rd ? cmd.wide_addr : row_full[WADDR_W-1:0];
    assign i_rd_en   = (rec_acc && inner_hit) || cmd.inner_rd;
    assign i_rd_addr = cmd.inner_rd ? cmd.inner_addr : side_idx;

    qrci_store #(
        .DEPTH  (WROWS),
        .WIDTH  ($bits(row_t)),
        .ADDR_W (WADDR_W)
    ) u_wide_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (w_rd_en),
        .rd_clr  (cmd.wide_rd),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data),
        .wr_en   (upd_w_vld_reg),
        .wr_addr (upd_row_reg),
        .wr_data (w_new)
    );

    qrci_store #(
        .DEPTH  (IROWS),
        .WIDTH  ($bits(row_t)),
        .ADDR_W (IADDR_W)
    ) u_inner_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (i_rd_en),
        .rd_clr  (cmd.inner_rd),
        .rd_addr (i_rd_addr),
        .rd_data (i_rd_data),
        .wr_en   (upd_i_vld_reg),
        .wr_addr (upd_side_reg),
        .wr_data (i_new)
    );

    // Hold the record while its rows are read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_w_vld_reg <= 1'b0;
            upd_i_vld_reg <= 1'b0;
            fw_w_vld_reg  <= 1'b0;
            fw_i_vld_reg  <= 1'b0;
        end
        else
        begin
            upd_w_vld_reg <= rec_acc && wide_hit;
            upd_i_vld_reg <= rec_acc && inner_hit;
            fw_w_vld_reg  <= upd_w_vld_reg;
            fw_i_vld_reg  <= upd_i_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        upd_row_reg   <= row_full[WADDR_W-1:0];
        upd_side_reg  <= side_idx;
        upd_q_reg     <= quarter;
        upd_cnt_reg   <= cluster_count;
        fw_w_row_reg  <= upd_row_reg;
        fw_w_data_reg <= w_new;
        fw_i_addr_reg <= upd_side_reg;
        fw_i_data_reg <= i_new;
    end

    // Modify: forward a row written in the same cycle it was read, then add
    always_comb
    begin
        w_base = (fw_w_vld_reg && fw_w_row_reg == upd_row_reg) ? fw_w_data_reg : w_rd_data;
        i_base = (fw_i_vld_reg && fw_i_addr_reg == upd_side_reg) ? fw_i_data_reg : i_rd_data;
        w_new  = w_base;
        i_new  = i_base;
        w_new[upd_q_reg] = sat_add(w_base[upd_q_reg], upd_cnt_reg);
        i_new[upd_q_reg] = sat_add(i_base[upd_q_reg], upd_cnt_reg);
    end

    // Advance the event counters and check the windows
    always_comb
    begin
        wide_inc      = {1'b0, wide_ev_reg} + WIN_W'(1);
        inner_inc     = {1'b0, inner_ev_reg} + WIN_W'(1);
        fire_w        = wide_inc >= eff_window(cfg.wide_win);
        fire_i        = inner_inc >= eff_window(cfg.inner_win);
        wide_ev_next  = fire_w ? '0 : wide_inc[EV_W-1:0];
        inner_ev_next = fire_i ? '0 : inner_inc[EV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_ev_reg  <= '0;
            inner_ev_reg <= '0;
        end
        else if (ev_acc)
        begin
            wide_ev_reg  <= wide_ev_next;
            inner_ev_reg <= inner_ev_next;
        end
    end

    qrci_flush u_flush (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_wide  (ev_acc && fire_w),
        .start_inner (ev_acc && fire_i),
        .busy        (flush_busy),
        .cmd         (cmd)
    );

    // Track the flush row alongside its RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fl_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            fl_vld_reg  <= cmd.wide_rd || cmd.inner_rd;
            out_vld_reg <= fl_vld_reg;
        end
    end

    assign fl_data = (fl_kind_reg == KIND_INNER) ? i_rd_data : w_rd_data;

    always_ff @(posedge clk)
    begin
        fl_kind_reg   <= cmd.inner_rd ? KIND_INNER : KIND_WIDE;
        fl_dslot_reg  <= cmd.disk_slot;
        fl_rslot_reg  <= cmd.ring_slot;
        fl_last_reg   <= cmd.last;
        out_kind_reg  <= fl_kind_reg;
        out_dslot_reg <= fl_dslot_reg;
        out_rslot_reg <= fl_rslot_reg;
        out_last_reg  <= fl_last_reg;
        out_data_reg  <= fl_data;
    end

    // Drive the result word
    assign strobe         = out_vld_reg;
    assign record_kind    = out_kind_reg;
    assign disk_slot      = out_dslot_reg;
    assign ring_slot      = out_rslot_reg;
    assign count_quarter0 = out_data_reg[0][OUT_W-1:0];
    assign count_quarter1 = out_data_reg[1][OUT_W-1:0];
    assign count_quarter2 = out_data_reg[2][OUT_W-1:0];
    assign count_quarter3 = out_data_reg[3][OUT_W-1:0];
    assign last_row       = out_last_reg;

endmodule

// File: tb/quarter_ring_cluster_integrator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench: predicts the quarter ring rows and checks every emitted word.
module quarter_ring_cluster_integrator_tb;
    import qrci_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 48;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_WORDS   = 90;
    localparam int LONG_EVENTS   = 24;
    localparam int FINAL_RECORDS = 8;
    localparam int ROWS_MAX      = DISK_SLOTS * RINGS + SIDES;

    typedef struct packed {
        logic                op;
        logic                fpix;
        logic [1:0]          side;
        logic [3:0]          disk;
        logic [2:0]          ring;
        logic [5:0]          module_pos;
        logic [CNT_IN_W-1:0] count;
    } word_t;

    localparam int WORD_W = $bits(word_t);

    typedef struct packed {
        logic                            kind;
        logic [SLOT_W-1:0]               dslot;
        logic [SLOT_W-1:0]               rslot;
        logic [QUARTERS-1:0][OUT_W-1:0]  quarters;
        logic                            last_flag;
    } flush_row_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [2:0]          paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                start         = 1'b0;
    logic                busy;
    logic                op            = 1'b0;
    logic                forward_pixel = 1'b0;
    logic [1:0]          side_number   = '0;
    logic [3:0]          disk_number   = '0;
    logic [2:0]          ring_number   = '0;
    logic [5:0]          module_number = '0;
    logic [CNT_IN_W-1:0] cluster_count = '0;
    logic                strobe;
    logic                record_kind;
    logic [SLOT_W-1:0]   disk_slot;
    logic [SLOT_W-1:0]   ring_slot;
    logic [OUT_W-1:0]    count_quarter0;
    logic [OUT_W-1:0]    count_quarter1;
    logic [OUT_W-1:0]    count_quarter2;
    logic [OUT_W-1:0]    count_quarter3;
    logic                last_row;

    // Mirror of the integrator state
    logic [COUNT_BITS-1:0] ring_sums  [DISK_SLOTS][RINGS][QUARTERS];
    logic [COUNT_BITS-1:0] inner_sums [SIDES][QUARTERS];
    logic [EV_W-1:0]       wide_events;
    logic [EV_W-1:0]       inner_events;
    logic [WIN_W-1:0]      wide_window;
    logic [WIN_W-1:0]      inner_window;

    word_t      pending_words [$];
    flush_row_t expected_rows [$];
    word_t      next_word;
    word_t      taken_word;
    logic       word_taken = 1'b0;
    int         idle_pct = 0;
    int         errors = 0;
    int         words_taken = 0;
    int         events_taken = 0;
    int         rows_checked = 0;
    int         flushes = 0;
    int         windows_written = 0;
    int         cycle_count = 0;

    quarter_ring_cluster_integrator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .forward_pixel  (forward_pixel),
        .side_number    (side_number),
        .disk_number    (disk_number),
        .ring_number    (ring_number),
        .module_number  (module_number),
        .cluster_count  (cluster_count),
        .strobe         (strobe),
        .record_kind    (record_kind),
        .disk_slot      (disk_slot),
        .ring_slot      (ring_slot),
        .count_quarter0 (count_quarter0),
        .count_quarter1 (count_quarter1),
        .count_quarter2 (count_quarter2),
        .count_quarter3 (count_quarter3),
        .last_row       (last_row)
    );

    // Free-running clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Modules in one quarter of a ring (ring numbered from 1)
    function automatic int ring_span(input logic [2:0] ring);
        int span;
        case (ring)
            3'd1:    span = 5;
            3'd2:    span = 7;
            3'd3:    span = 9;
            3'd4:    span = 11;
            default: span = 12;
        endcase
        return span;
    endfunction

    function automatic int quarter_index(input logic [2:0] ring, input logic [5:0] module_pos);
        int span;
        int m;
        span = ring_span(ring);
        m    = int'(module_pos);
        if (m <= span)
            return 0;
        if (m <= 2 * span)
            return 1;
        if (m <= 3 * span)
            return 2;
        return 3;
    endfunction

    function automatic logic [COUNT_BITS-1:0] add_clamped(input logic [COUNT_BITS-1:0] a,
                                                          input logic [CNT_IN_W-1:0] b);
        logic [COUNT_BITS:0] total;
        total = {1'b0, a} + {{(COUNT_BITS + 1 - CNT_IN_W){1'b0}}, b};
        return total[COUNT_BITS] ? {COUNT_BITS{1'b1}} : total[COUNT_BITS-1:0];
    endfunction

    // Window as the block applies it: zero means one, cap at the maximum
    function automatic int window_len(input logic [WIN_W-1:0] w);
        if (w == '0)
            return 1;
        if (w > MAX_WINDOW)
            return int'(MAX_WINDOW);
        return int'(w);
    endfunction

    // Update the mirror with one taken word and queue the rows it causes
    task automatic apply_word(input word_t w);
        flush_row_t batch [ROWS_MAX];
        int         n;
        int         d;
        int         r;
        int         s;
        int         j;
        int         q;
        int         slot;
        int         nw;
        int         ni;
        logic       fire_w;
        logic       fire_i;
        n = 0;
        words_taken++;
        if (w.op == OP_RECORD)
        begin
            if (w.fpix && (w.side == SIDE_MINUS || w.side == SIDE_PLUS)
                && w.disk >= FIRST_DISK && w.disk <= LAST_DISK
                && w.ring >= 3'd1 && w.ring <= MAX_RING)
            begin
                q    = quarter_index(w.ring, w.module_pos);
                slot = (int'(w.side) - 1) * 4 + int'(w.disk) - int'(FIRST_DISK);
                if (slot < DISK_SLOTS && int'(w.ring) - 1 < RINGS)
                    ring_sums[slot][int'(w.ring) - 1][q] =
                        add_clamped(ring_sums[slot][int'(w.ring) - 1][q], w.count);
                if (w.disk == INNER_DISK && w.ring == 3'd1)
                    inner_sums[int'(w.side) - 1][q] =
                        add_clamped(inner_sums[int'(w.side) - 1][q], w.count);
            end
        end
        else
        begin
            events_taken++;
            nw     = int'(wide_events) + 1;
            ni     = int'(inner_events) + 1;
            fire_w = nw >= window_len(wide_window);
            fire_i = ni >= window_len(inner_window);
            wide_events  = fire_w ? '0 : EV_W'(nw);
            inner_events = fire_i ? '0 : EV_W'(ni);
            if (fire_w)
            begin
                for (d = 0; d < DISK_SLOTS; d++)
                begin
                    for (r = 0; r < RINGS; r++)
                    begin
                        batch[n].kind      = KIND_WIDE;
                        batch[n].dslot     = SLOT_W'(d);
                        batch[n].rslot     = SLOT_W'(r);
                        batch[n].last_flag = 1'b0;
                        for (j = 0; j < QUARTERS; j++)
                        begin
                            batch[n].quarters[j] = ring_sums[d][r][j][OUT_W-1:0];
                            ring_sums[d][r][j]   = '0;
                        end
                        n++;
                    end
                end
            end
            if (fire_i)
            begin
                for (s = 0; s < SIDES; s++)
                begin
                    batch[n].kind      = KIND_INNER;
                    batch[n].dslot     = SLOT_W'(s);
                    batch[n].rslot     = '0;
                    batch[n].last_flag = 1'b0;
                    for (j = 0; j < QUARTERS; j++)
                    begin
                        batch[n].quarters[j] = inner_sums[s][j][OUT_W-1:0];
                        inner_sums[s][j]     = '0;
                    end
                    n++;
                end
            end
            if (n > 0)
            begin
                flushes++;
                batch[n - 1].last_flag = 1'b1;
            end
            for (j = 0; j < n; j++)
                expected_rows.push_back(batch[j]);
        end
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare one emitted row with the oldest expectation
    task automatic check_row();
        flush_row_t want;
        if (expected_rows.size() == 0)
        begin
            $display("%0t: unexpected row, expected none, got kind %0d slot %0d/%0d",
                     $time, record_kind, disk_slot, ring_slot);
            errors++;
        end
        else
        begin
            want = expected_rows.pop_front();
            rows_checked++;
            check_field("record_kind", OUT_W'(want.kind), OUT_W'(record_kind));
            check_field("disk_slot", OUT_W'(want.dslot), OUT_W'(disk_slot));
            check_field("ring_slot", OUT_W'(want.rslot), OUT_W'(ring_slot));
            check_field("count_quarter0", want.quarters[0], count_quarter0);
            check_field("count_quarter1", want.quarters[1], count_quarter1);
            check_field("count_quarter2", want.quarters[2], count_quarter2);
            check_field("count_quarter3", want.quarters[3], count_quarter3);
            check_field("last_row", OUT_W'(want.last_flag), OUT_W'(last_row));
        end
    endtask

    // Drive the next word once the current one has been taken
    always @(negedge clk)
    begin
        if (rst_n && (!start || word_taken))
        begin
            if (pending_words.size() != 0 && $urandom_range(99, 0) >= idle_pct)
            begin
                next_word = pending_words.pop_front();
                start         <= 1'b1;
                op            <= next_word.op;
                forward_pixel <= next_word.fpix;
                side_number   <= next_word.side;
                disk_number   <= next_word.disk;
                ring_number   <= next_word.ring;
                module_number <= next_word.module_pos;
                cluster_count <= next_word.count;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Check emitted rows and predict from taken words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_taken <= start && !busy;
            if (strobe)
                check_row();
            if (start && !busy)
            begin
                taken_word = {op, forward_pixel, side_number, disk_number, ring_number,
                              module_number, cluster_count};
                apply_word(taken_word);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d rows still expected",
                     cycle_count, expected_rows.size());
            $display("quarter_ring_cluster_integrator_tb failed");
            $finish;
        end
    end

    function automatic word_t record_word(input logic fpix, input logic [1:0] side,
                                          input logic [3:0] disk, input logic [2:0] ring,
                                          input logic [5:0] module_pos,
                                          input logic [CNT_IN_W-1:0] count);
        word_t w;
        w.op         = OP_RECORD;
        w.fpix       = fpix;
        w.side       = side;
        w.disk       = disk;
        w.ring       = ring;
        w.module_pos = module_pos;
        w.count      = count;
        return w;
    endfunction

    // Well-formed record with random content, leaning on the inner ring now and then
    function automatic word_t random_record();
        word_t w;
        w.op   = OP_RECORD;
        w.fpix = 1'b1;
        w.side = ($urandom_range(1, 0) == 1) ? SIDE_PLUS : SIDE_MINUS;
        if ($urandom_range(4, 0) == 0)
        begin
            w.disk = INNER_DISK;
            w.ring = 3'd1;
        end
        else
        begin
            w.disk = FIRST_DISK + 4'($urandom_range(3, 0));
            w.ring = 3'($urandom_range(int'(MAX_RING), 1));
        end
        if ($urandom_range(9, 0) < 8)
            w.module_pos = 6'($urandom_range(4 * ring_span(w.ring), 1));
        else
            w.module_pos = 6'($urandom_range(63, 0));
        if ($urandom_range(1, 0) == 1)
            w.count = CNT_IN_W'($urandom);
        else
            w.count = CNT_IN_W'($urandom_range(255, 0));
        return w;
    endfunction

    function automatic word_t noise_word();
        word_t w;
        w    = word_t'(WORD_W'({$urandom, $urandom}));
        w.op = OP_RECORD;
        return w;
    endfunction

    function automatic word_t end_of_event_word();
        word_t w;
        w    = word_t'(WORD_W'({$urandom, $urandom}));
        w.op = OP_EVENT;
        return w;
    endfunction

    // Wait until every word is taken and every row has come out
    task automatic drain();
        while (pending_words.size() != 0 || start || expected_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one window register over APB, then read it back
    task automatic set_window(input logic idx, input logic [31:0] value);
        logic [31:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == REG_WIDE_WIN)
            wide_window = value[WIN_W-1:0];
        else
            inner_window = value[WIN_W-1:0];
        windows_written++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== 32'(value[WIN_W-1:0]))
        begin
            $display("%0t: window register %0d readback mismatch, expected %0h, got %0h",
                     $time, idx, 32'(value[WIN_W-1:0]), readback);
            errors++;
        end
    endtask

    // Mostly well-formed records and event ends, the rest noise
    task automatic queue_random(input int target);
        int useful;
        int pick;
        useful = 0;
        while (useful < target)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 17)
            begin
                pending_words.push_back(end_of_event_word());
                useful++;
            end
            else if (pick < 30)
            begin
                pending_words.push_back(noise_word());
            end
            else
            begin
                pending_words.push_back(random_record());
                useful++;
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] wide_val, input logic [31:0] inner_val,
                             input int idle);
        set_window(REG_WIDE_WIN, wide_val);
        set_window(REG_INNER_WIN, inner_val);
        idle_pct = idle;
        queue_random(PHASE_WORDS);
        drain();
    endtask

    initial
    begin
        word_t w;
        int    i;
        int    d;
        int    r;
        int    j;

        // Mirror starts from the reset state
        for (d = 0; d < DISK_SLOTS; d++)
            for (r = 0; r < RINGS; r++)
                for (j = 0; j < QUARTERS; j++)
                    ring_sums[d][r][j] = '0;
        for (d = 0; d < SIDES; d++)
            for (j = 0; j < QUARTERS; j++)
                inner_sums[d][j] = '0;
        wide_events  = '0;
        inner_events = '0;
        wide_window  = WIN_W'(1);
        inner_window = WIN_W'(1);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset windows: quarter edges, inner ring, ignored records
        idle_pct = 0;
        pending_words.push_back(record_word(1'b1, SIDE_MINUS, 4'd9, 3'd1, 6'd0, 16'hFFFF));
        pending_words.push_back(record_word(1'b1, SIDE_PLUS, 4'd12, 3'd1, 6'd20, 16'h0001));
        pending_words.push_back(record_word(1'b1, SIDE_PLUS, 4'd12, 3'd5, 6'd63, 16'h8000));
        pending_words.push_back(record_word(1'b1, SIDE_MINUS, 4'd12, 3'd1, 6'd5, 16'h0007));
        pending_words.push_back(record_word(1'b1, SIDE_MINUS, 4'd12, 3'd1, 6'd6, 16'h0003));
        pending_words.push_back(record_word(1'b1, SIDE_MINUS, 4'd12, 3'd1, 6'd11, 16'h0002));
        pending_words.push_back(record_word(1'b1, SIDE_MINUS, 4'd12, 3'd1, 6'd16, 16'h0005));
        pending_words.push_back(record_word(1'b1, SIDE_PLUS, 4'd11, 3'd4, 6'd44, 16'h0000));
        pending_words.push_back(record_word(1'b1, SIDE_MINUS, 4'd10, 3'd3, 6'd18, 16'hAAAA));
        pending_words.push_back(record_word(1'b1, SIDE_PLUS, 4'd9, 3'd2, 6'd28, 16'h5555));
        pending_words.push_back(record_word(1'b0, SIDE_MINUS, 4'd9, 3'd1, 6'd1, 16'h0100));
        pending_words.push_back(record_word(1'b1, 2'd0, 4'd9, 3'd1, 6'd1, 16'h0100));
        pending_words.push_back(record_word(1'b1, 2'd3, 4'd12, 3'd1, 6'd1, 16'h0100));
        pending_words.push_back(record_word(1'b1, SIDE_MINUS, 4'd8, 3'd1, 6'd1, 16'h0100));
        pending_words.push_back(record_word(1'b1, SIDE_MINUS, 4'd13, 3'd1, 6'd1, 16'h0100));
        pending_words.push_back(record_word(1'b1, SIDE_PLUS, 4'd0, 3'd1, 6'd1, 16'h0100));
        pending_words.push_back(record_word(1'b1, SIDE_PLUS, 4'd9, 3'd0, 6'd1, 16'h0100));
        pending_words.push_back(record_word(1'b1, SIDE_PLUS, 4'd9, 3'd6, 6'd1, 16'h0100));
        pending_words.push_back(record_word(1'b1, SIDE_PLUS, 4'd15, 3'd7, 6'd63, 16'hFFFF));
        w    = '0;
        w.op = OP_EVENT;
        pending_words.push_back(w);
        pending_words.push_back(record_word(1'b1, SIDE_MINUS, 4'd12, 3'd1, 6'd1, 16'hFFFF));
        pending_words.push_back('1);
        drain();

        // Random phases over several window settings and idle rates
        run_phase(32'hFFFF_8000, 32'h0000_0000, 0);
        run_phase(32'd3, 32'd7, 61);
        run_phase(32'd2, 32'd5, 28);
        run_phase(32'd6, 32'd1, 0);

        // Largest window on both stores, one over the cap: events build up without a flush
        set_window(REG_WIDE_WIN, 32'h0000_7FFF);
        set_window(REG_INNER_WIN, 32'd16384);
        idle_pct = 0;
        for (i = 0; i < LONG_EVENTS; i++)
        begin
            if ($urandom_range(49, 0) == 0)
                pending_words.push_back(random_record());
            pending_words.push_back(end_of_event_word());
        end
        drain();

        // Drop both windows to one, load the inner ring, then flush everything at once
        set_window(REG_WIDE_WIN, 32'h5A5A_0001);
        set_window(REG_INNER_WIN, 32'd1);
        for (i = 0; i < FINAL_RECORDS; i++)
            pending_words.push_back(record_word(1'b1, SIDE_MINUS, INNER_DISK, 3'd1, 6'd1,
                                                16'hFFFF));
        pending_words.push_back(end_of_event_word());
        drain();

        repeat (END_CYCLES) @(posedge clk);
        $display("run covered %0d words (%0d event ends), %0d flushes, %0d rows checked",
                 words_taken, events_taken, flushes, rows_checked);
        $display("window registers written %0d times, %0d mismatches", windows_written, errors);
        if (errors == 0)
            $display("quarter_ring_cluster_integrator_tb passed");
        else
            $display("quarter_ring_cluster_integrator_tb failed");
        $finish;
    end

endmodule
